>>> rtl/csrs_pkg.sv
// Shared types and constants for the command stream readback snooper.
// No dependencies; used by the parser, the table and the top level.
package csrs_pkg;

  localparam logic [7:0]  OP_XFER3D           = 8'd43;
  localparam logic [7:0]  OP_COPY_XFER3D      = 8'd45;
  localparam logic [15:0] XFER3D_MIN_LEN      = 16'd13;
  localparam logic [15:0] COPY_XFER3D_LEN     = 16'd14;
  localparam logic [31:0] XFER_FROM_HOST      = 32'd2;
  localparam int unsigned COPY_READ_FROM_HOST = 1;   // bit position in payload word 14
  localparam int unsigned NUM_CAPTURED        = 8;

  // one row of the hint table
  typedef struct packed {
    logic [31:0] resource;
    logic [31:0] level;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] width;
    logic [31:0] height;
  } hint_t;

  // parser -> table request
  typedef struct packed {
    logic  valid;
    logic  add;    // command qualified, record its hint
    logic  eos;    // stream ended, emit the table
    logic  cut;    // stream ended inside a command
    hint_t hint;
  } req_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_SRCH_RD,
    T_SRCH_CMP,
    T_EMIT_RD,
    T_EMIT_LD
  } tbl_state_t;

endpackage

>>> rtl/csrs_in_if.sv
// Input channel: command stream words with an end-of-stream mark.
// Standalone interface, no dependencies.
interface csrs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] stream_word;
  logic        end_of_stream;

  modport source (output valid, output stream_word, output end_of_stream, input ready);
  modport sink   (input valid, input stream_word, input end_of_stream, output ready);
endinterface

>>> rtl/csrs_out_if.sv
// Output channel: one hint table entry per word.
// Standalone interface, no dependencies.
interface csrs_out_if;
  logic        valid;
  logic        ready;
  logic        entry_valid;
  logic [31:0] hint_resource;
  logic [31:0] hint_level;
  logic [31:0] hint_x;
  logic [31:0] hint_y;
  logic [31:0] hint_width;
  logic [31:0] hint_height;
  logic [3:0]  hints_total;
  logic        stream_cut_short;
  logic        last_of_run;

  modport source (output valid, output entry_valid, output hint_resource, output hint_level,
                  output hint_x, output hint_y, output hint_width, output hint_height,
                  output hints_total, output stream_cut_short, output last_of_run,
                  input ready);
  modport sink   (input valid, input entry_valid, input hint_resource, input hint_level,
                  input hint_x, input hint_y, input hint_width, input hint_height,
                  input hints_total, input stream_cut_short, input last_of_run,
                  output ready);
endinterface

>>> rtl/csrs_parser.sv
// Command parser: tracks header/payload position, captures payload fields and
// raises a request to the hint table. Depends on csrs_pkg and csrs_in_if.
module csrs_parser (
  input  logic            clk,
  input  logic            rst,
  csrs_in_if.sink         cmd_in,
  input  logic            busy,
  output csrs_pkg::req_t  req
);

  logic [16:0] word_in_command, word_in_command_next;
  logic [15:0] payload_length, payload_length_next;
  logic [7:0]  command_opcode, command_opcode_next;
  logic [31:0] cap [csrs_pkg::NUM_CAPTURED];
  logic [31:0] cap_next [csrs_pkg::NUM_CAPTURED];
  logic        req_valid, req_valid_next;
  logic        req_add, req_add_next;
  logic        req_eos, req_eos_next;
  logic        req_cut, req_cut_next;
  logic        accept;
  logic        qualify;

  // hold off while the table is working or a request is still pending
  assign cmd_in.ready = !busy && !req_valid;
  assign accept = cmd_in.valid && cmd_in.ready;

  always_comb begin
    word_in_command_next = word_in_command;
    payload_length_next  = payload_length;
    command_opcode_next  = command_opcode;
    for (int i = 0; i < csrs_pkg::NUM_CAPTURED; i++) begin
      cap_next[i] = cap[i];
    end
    qualify        = 1'b0;
    req_add_next   = 1'b0;
    req_eos_next   = 1'b0;
    req_cut_next   = 1'b0;
    req_valid_next = 1'b0;

    if (accept) begin
      if (word_in_command == '0) begin
        payload_length_next = cmd_in.stream_word[31:16];
        command_opcode_next = cmd_in.stream_word[7:0];
        for (int i = 0; i < csrs_pkg::NUM_CAPTURED; i++) begin
          cap_next[i] = '0;
        end
        word_in_command_next = (cmd_in.stream_word[31:16] != '0) ? 17'd1 : 17'd0;
      end else begin
        case (word_in_command)
          17'd1:   cap_next[0] = cmd_in.stream_word;
          17'd2:   cap_next[1] = cmd_in.stream_word;
          17'd6:   cap_next[2] = cmd_in.stream_word;
          17'd7:   cap_next[3] = cmd_in.stream_word;
          17'd9:   cap_next[4] = cmd_in.stream_word;
          17'd10:  cap_next[5] = cmd_in.stream_word;
          17'd13:  cap_next[6] = cmd_in.stream_word;
          17'd14:  cap_next[7] = cmd_in.stream_word;
          default: ;
        endcase
        if (word_in_command >= {1'b0, payload_length}) begin
          qualify = (command_opcode == csrs_pkg::OP_XFER3D &&
                     payload_length >= csrs_pkg::XFER3D_MIN_LEN &&
                     cap_next[6] == csrs_pkg::XFER_FROM_HOST) ||
                    (command_opcode == csrs_pkg::OP_COPY_XFER3D &&
                     payload_length == csrs_pkg::COPY_XFER3D_LEN &&
                     cap_next[7][csrs_pkg::COPY_READ_FROM_HOST]);
          word_in_command_next = '0;
        end else begin
          word_in_command_next = word_in_command + 17'd1;
        end
      end

      req_add_next = qualify;
      if (cmd_in.end_of_stream) begin
        req_eos_next         = 1'b1;
        req_cut_next         = (word_in_command_next != '0);
        word_in_command_next = '0;
      end
      req_valid_next = qualify || cmd_in.end_of_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_in_command <= '0;
      payload_length  <= '0;
      command_opcode  <= '0;
      req_valid       <= 1'b0;
      req_add         <= 1'b0;
      req_eos         <= 1'b0;
      req_cut         <= 1'b0;
    end else begin
      word_in_command <= word_in_command_next;
      payload_length  <= payload_length_next;
      command_opcode  <= command_opcode_next;
      req_valid       <= req_valid_next;
      req_add         <= req_add_next;
      req_eos         <= req_eos_next;
      req_cut         <= req_cut_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < csrs_pkg::NUM_CAPTURED; i++) begin
      cap[i] <= cap_next[i];
    end
  end

  // captured words stay put while the table works: no word is taken then
  assign req.valid         = req_valid;
  assign req.add           = req_add;
  assign req.eos           = req_eos;
  assign req.cut           = req_cut;
  assign req.hint.resource = cap[0];
  assign req.hint.level    = cap[1];
  assign req.hint.x        = cap[2];
  assign req.hint.y        = cap[3];
  assign req.hint.width    = cap[4];
  assign req.hint.height   = cap[5];

endmodule

>>> rtl/csrs_table.sv
// Hint table: ring buffer in a synchronous memory, resource search, update
// and end-of-stream drain through an output register. Depends on csrs_pkg and csrs_out_if.
module csrs_table #(
  parameter int MAX_HINTS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  csrs_pkg::req_t  req,
  output logic            busy,
  csrs_out_if.source      hint_out
);

  localparam int IW = (MAX_HINTS > 1) ? $clog2(MAX_HINTS) : 1;
  localparam int CW = $clog2(MAX_HINTS + 1);

  csrs_pkg::tbl_state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] head, head_next;
  logic [CW-1:0] k, k_next;
  logic          eos_p, eos_p_next;
  logic          cut, cut_next;

  csrs_pkg::hint_t mem [MAX_HINTS];
  csrs_pkg::hint_t rdata;
  logic [IW-1:0]   rd_addr;
  logic [IW-1:0]   app_addr;
  logic [IW-1:0]   waddr;
  logic            we;
  logic            last_k;
  logic            out_free;
  logic            load;
  logic            load_entry;

  logic            ov;
  csrs_pkg::hint_t out_hint;
  logic            out_ev;
  logic [3:0]      out_total;
  logic            out_cut;
  logic            out_last;

  // logical position -> physical row, oldest entry sits at head
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] i);
    logic [IW:0] s;
    s = {1'b0, h} + (IW+1)'(i);
    if (s >= (IW+1)'(MAX_HINTS)) begin
      s = s - (IW+1)'(MAX_HINTS);
    end
    return s[IW-1:0];
  endfunction

  assign rd_addr  = phys(head, k);
  assign app_addr = phys(head, count);
  assign last_k   = (({1'b0, k} + 1'b1) == {1'b0, count});
  assign out_free = !ov || hint_out.ready;
  assign busy     = (state != csrs_pkg::T_IDLE);

  always_comb begin
    state_next = state;
    count_next = count;
    head_next  = head;
    k_next     = k;
    eos_p_next = eos_p;
    cut_next   = cut;
    we         = 1'b0;
    waddr      = app_addr;
    load       = 1'b0;
    load_entry = 1'b0;

    unique case (state)
      csrs_pkg::T_IDLE: begin
        if (req.valid) begin
          eos_p_next = req.eos;
          cut_next   = req.cut;
          k_next     = '0;
          if (req.add && count == '0) begin
            we         = 1'b1;
            count_next = CW'(1);
            state_next = req.eos ? csrs_pkg::T_EMIT_RD : csrs_pkg::T_IDLE;
          end else if (req.add) begin
            state_next = csrs_pkg::T_SRCH_RD;
          end else begin
            state_next = csrs_pkg::T_EMIT_RD;
          end
        end
      end

      csrs_pkg::T_SRCH_RD: begin
        state_next = csrs_pkg::T_SRCH_CMP;
      end

      csrs_pkg::T_SRCH_CMP: begin
        if (rdata.resource == req.hint.resource || last_k) begin
          we = 1'b1;
          if (rdata.resource == req.hint.resource) begin
            waddr = rd_addr;
          end else if (count == CW'(MAX_HINTS)) begin
            // full: drop the oldest, the new hint becomes the newest
            waddr     = head;
            head_next = (head == IW'(MAX_HINTS - 1)) ? '0 : head + 1'b1;
          end else begin
            count_next = count + 1'b1;
          end
          k_next     = '0;
          state_next = eos_p ? csrs_pkg::T_EMIT_RD : csrs_pkg::T_IDLE;
        end else begin
          k_next     = k + 1'b1;
          state_next = csrs_pkg::T_SRCH_RD;
        end
      end

      csrs_pkg::T_EMIT_RD: begin
        if (out_free) begin
          if (count == '0) begin
            load       = 1'b1;
            head_next  = '0;
            state_next = csrs_pkg::T_IDLE;
          end else begin
            state_next = csrs_pkg::T_EMIT_LD;
          end
        end
      end

      csrs_pkg::T_EMIT_LD: begin
        // output register was free when the read went out
        load       = 1'b1;
        load_entry = 1'b1;
        if (last_k) begin
          count_next = '0;
          head_next  = '0;
          k_next     = '0;
          state_next = csrs_pkg::T_IDLE;
        end else begin
          k_next     = k + 1'b1;
          state_next = csrs_pkg::T_EMIT_RD;
        end
      end

      default: state_next = csrs_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csrs_pkg::T_IDLE;
      count <= '0;
      head  <= '0;
      k     <= '0;
      eos_p <= 1'b0;
      cut   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      head  <= head_next;
      k     <= k_next;
      eos_p <= eos_p_next;
      cut   <= cut_next;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= req.hint;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load) begin
      ov <= 1'b1;
    end else if (hint_out.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_hint  <= load_entry ? rdata : '0;
      out_ev    <= load_entry;
      out_total <= load_entry ? 4'(count) : 4'd0;
      out_cut   <= cut;
      out_last  <= load_entry ? last_k : 1'b1;
    end
  end

  assign hint_out.valid            = ov;
  assign hint_out.entry_valid      = out_ev;
  assign hint_out.hint_resource    = out_hint.resource;
  assign hint_out.hint_level       = out_hint.level;
  assign hint_out.hint_x           = out_hint.x;
  assign hint_out.hint_y           = out_hint.y;
  assign hint_out.hint_width       = out_hint.width;
  assign hint_out.hint_height      = out_hint.height;
  assign hint_out.hints_total      = out_total;
  assign hint_out.stream_cut_short = out_cut;
  assign hint_out.last_of_run      = out_last;

endmodule

>>> rtl/command_stream_readback_snooper.sv
// Top level of the command stream readback snooper.
// Depends on csrs_pkg, csrs_in_if, csrs_out_if, csrs_parser and csrs_table.
//
// Watches a command stream one 32-bit word per handshake and records a hint
// (resource, level, x, y, width, height) for every 3D transfer from host and
// every copy transfer that reads from host; at the end-of-stream word the hint
// table is sent out, one entry per output word, with last_of_run on the final
// one (a single empty entry when no hint was seen), then table and parser
// start fresh. Input is held off while a request is pending or the table is
// busy: the word completing a qualifying command waits while the table's read
// port is searched entry by entry (up to MAX_HINTS; none if the table is empty)
// for the resource, and the end-of-stream word then drains the table entry by
// entry through the same read port. A new word may be taken while the last
// result still waits in the output register. The table memory needs no
// clearing pass: a fill count marks which rows hold data.
module command_stream_readback_snooper #(
  parameter int MAX_HINTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  csrs_in_if.sink     cmd_in,
  csrs_out_if.source  hint_out
);

  csrs_pkg::req_t req;
  logic           busy;

  csrs_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .cmd_in (cmd_in),
    .busy   (busy),
    .req    (req)
  );

  csrs_table #(
    .MAX_HINTS (MAX_HINTS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .busy     (busy),
    .hint_out (hint_out)
  );

endmodule

>>> rtl/csrs_checker.sv
// Port-level checks for the command stream readback snooper, bound to the top.
// Depends only on the top level's ports.
module csrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_eos,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_entry_valid,
  input logic [31:0] out_resource,
  input logic [3:0]  out_total,
  input logic        out_last
);

  // streams ended but not fully delivered yet
  logic [1:0] runs_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      runs_open <= '0;
    end else begin
      runs_open <= runs_open + 2'(in_valid && in_ready && in_eos)
                             - 2'(out_valid && out_ready && out_last);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_resource) && $stable(out_last))
    else $error("result word changed while stalled");

  a_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> runs_open != 2'd0)
    else $error("result word without a finished stream");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_entry_valid |-> out_last && out_total == 4'd0 && out_resource == '0)
    else $error("empty-table word malformed");

endmodule

bind command_stream_readback_snooper csrs_checker u_csrs_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (cmd_in.valid),
  .in_ready        (cmd_in.ready),
  .in_eos          (cmd_in.end_of_stream),
  .out_valid       (hint_out.valid),
  .out_ready       (hint_out.ready),
  .out_entry_valid (hint_out.entry_valid),
  .out_resource    (hint_out.hint_resource),
  .out_total       (hint_out.hints_total),
  .out_last        (hint_out.last_of_run)
);
